// File: rtl/core/xbr_pkg.sv
// ----------------------------------------------------------------------------
// xbr_pkg
// Shared types and constants for the xorshift128+ bounded random source.
// ----------------------------------------------------------------------------
`default_nettype none

package xbr_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned CntW  = 7;

  localparam int unsigned ShiftA = 23;
  localparam int unsigned ShiftB = 17;
  localparam int unsigned ShiftC = 26;

  localparam logic [1:0] REQ_RAW     = 2'd0;
  localparam logic [1:0] REQ_BOUNDED = 2'd1;
  localparam logic [1:0] REQ_RESEED  = 2'd2;

  localparam logic CFG_SEED_A = 1'b0;
  localparam logic CFG_SEED_B = 1'b1;

  localparam logic [WordW-1:0] SEED_A_RST = 64'd1;
  localparam logic [WordW-1:0] SEED_B_RST = 64'd2;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rem_status_t;

endpackage

`default_nettype wire

// File: rtl/core/xorshift128_plus_bounded_random_top.sv
// ----------------------------------------------------------------------------
// xorshift128_plus_bounded_random_top
// xorshift128+ random source with raw, bounded and reseed requests.
// ----------------------------------------------------------------------------
// Usage: an item on the input channel (in_valid, in_stall) carries a request
// type and a bound. Each item yields exactly one item on the output channel
// (out_valid, out_stall) with a value and a bad-bound flag. Raw draws return
// the xorshift128+ output; bounded draws return a value uniform below the
// bound; reseeds load the state from the two seed registers written over
// the cfg port, which the user must write only while the block is idle; the
// block itself does not enforce this. A raw, reseed, zero-bound or unused item
// goes from the execution state to the finish state, which loads the output.
// A bounded draw with a nonzero bound draws a value, runs the bit-serial
// remainder unit, checks the attempt and then loads the output. A rejected
// attempt draws again; rejection is rare for small bounds but common for
// bounds just above 2^63. The block takes one item at a time and holds
// in_stall high while working. The finished result sits in an output
// register, so the next item can be accepted while the receiver stalls;
// that item then waits at its end until the output register frees up.
// Reset loads both seeds and the state with 1 and 2 and empties the output.
// ----------------------------------------------------------------------------
`default_nettype none

module xorshift128_plus_bounded_random_top (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire         cfg_index,
  input  wire  [63:0] cfg_wdata,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  in_req_type,
  input  wire  [63:0] in_bound,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [63:0] out_value,
  output logic        out_bad_bound
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t               state_r, state_nxt;
  logic [1:0]           req_r, req_nxt;
  xbr_pkg::word_t       bound_r, bound_nxt;
  xbr_pkg::word_t       sa_r, sa_nxt;
  xbr_pkg::word_t       sb_r, sb_nxt;
  xbr_pkg::word_t       seed_a_r, seed_a_nxt;
  xbr_pkg::word_t       seed_b_r, seed_b_nxt;
  xbr_pkg::word_t       x_r, x_nxt;
  xbr_pkg::word_t       res_val_r, res_val_nxt;
  logic                 res_bad_r, res_bad_nxt;
  logic                 out_valid_r, out_valid_nxt;
  xbr_pkg::word_t       out_value_r, out_value_nxt;
  logic                 out_bad_r, out_bad_nxt;

  xbr_pkg::word_t       step_a, step_b, step_draw;
  xbr_pkg::word_t       rem_val;
  xbr_pkg::rem_status_t rem_stat;
  logic                 rem_start;
  xbr_pkg::word_t       base;
  logic [xbr_pkg::WordW:0] top_sum;
  logic                 in_take;
  logic                 out_free;

  xbr_step u_step (
    .state_a (sa_r),
    .state_b (sb_r),
    .next_a  (step_a),
    .next_b  (step_b),
    .draw    (step_draw)
  );

  xbr_rem u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (rem_start),
    .dividend  (step_draw),
    .divisor   (bound_r),
    .remainder (rem_val),
    .status    (rem_stat)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign rem_start = (state_r == ST_EXEC) && (req_r == xbr_pkg::REQ_BOUNDED) &&
                     (bound_r != '0);
  assign base      = x_r - rem_val;
  assign top_sum   = {1'b0, base} + {1'b0, bound_r};

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    bound_nxt     = bound_r;
    sa_nxt        = sa_r;
    sb_nxt        = sb_r;
    seed_a_nxt    = seed_a_r;
    seed_b_nxt    = seed_b_r;
    x_nxt         = x_r;
    res_val_nxt   = res_val_r;
    res_bad_nxt   = res_bad_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_bad_nxt   = out_bad_r;

    if (cfg_we) begin
      case (cfg_index)
        xbr_pkg::CFG_SEED_A: seed_a_nxt = cfg_wdata;
        xbr_pkg::CFG_SEED_B: seed_b_nxt = cfg_wdata;
        default: ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          req_nxt   = in_req_type;
          bound_nxt = in_bound;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_val_nxt = '0;
        res_bad_nxt = 1'b0;
        state_nxt   = ST_FIN;
        case (req_r)
          xbr_pkg::REQ_RAW: begin
            sa_nxt      = step_a;
            sb_nxt      = step_b;
            res_val_nxt = step_draw;
          end
          xbr_pkg::REQ_BOUNDED: begin
            if (bound_r == '0) begin
              res_bad_nxt = 1'b1;
            end else begin
              sa_nxt    = step_a;
              sb_nxt    = step_b;
              x_nxt     = step_draw;
              state_nxt = ST_DIV;
            end
          end
          xbr_pkg::REQ_RESEED: begin
            sa_nxt = seed_a_r;
            sb_nxt = seed_b_r;
          end
          default: ;
        endcase
      end
      ST_DIV: begin
        if (rem_stat.done) begin
          if (top_sum[xbr_pkg::WordW]) begin
            state_nxt = ST_EXEC;
          end else begin
            res_val_nxt = rem_val;
            state_nxt   = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_val_r;
          out_bad_nxt   = res_bad_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      sa_r        <= xbr_pkg::SEED_A_RST;
      sb_r        <= xbr_pkg::SEED_B_RST;
      seed_a_r    <= xbr_pkg::SEED_A_RST;
      seed_b_r    <= xbr_pkg::SEED_B_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sa_r        <= sa_nxt;
      sb_r        <= sb_nxt;
      seed_a_r    <= seed_a_nxt;
      seed_b_r    <= seed_b_nxt;
    end
    req_r       <= req_nxt;
    bound_r     <= bound_nxt;
    x_r         <= x_nxt;
    res_val_r   <= res_val_nxt;
    res_bad_r   <= res_bad_nxt;
    out_value_r <= out_value_nxt;
    out_bad_r   <= out_bad_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_bad_bound = out_bad_r;

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r == ST_EXEC))
    else $error("accepted item did not start execution");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    rem_stat.done |-> (state_r == ST_DIV))
    else $error("remainder result outside division state");

  a_busy_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    rem_stat.busy |-> (state_r == ST_DIV))
    else $error("remainder unit busy outside division state");

  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bad_r) |-> (out_value_r == '0))
    else $error("bad bound item carries nonzero value");

  a_bounded_below: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FIN) && (req_r == xbr_pkg::REQ_BOUNDED) && (bound_r != '0))
      |-> (res_val_r < bound_r))
    else $error("bounded result not below bound");

endmodule

`default_nettype wire

// File: rtl/core/xbr_step.sv
// ----------------------------------------------------------------------------
// xbr_step
// One xorshift128+ step: next state words and the draw they produce.
// ----------------------------------------------------------------------------
`default_nettype none

module xbr_step (
  input  xbr_pkg::word_t state_a,
  input  xbr_pkg::word_t state_b,
  output xbr_pkg::word_t next_a,
  output xbr_pkg::word_t next_b,
  output xbr_pkg::word_t draw
);

  xbr_pkg::word_t t;

  assign t      = state_a ^ (state_a << xbr_pkg::ShiftA);
  assign next_a = state_b;
  assign next_b = t ^ state_b ^ (t >> xbr_pkg::ShiftB) ^ (state_b >> xbr_pkg::ShiftC);
  assign draw   = next_b + state_b;

endmodule

`default_nettype wire

// File: rtl/core/xbr_rem.sv
// ----------------------------------------------------------------------------
// xbr_rem
// Restoring remainder unit: one dividend bit per cycle over the 64-bit dividend.
// ----------------------------------------------------------------------------
`default_nettype none

module xbr_rem (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  input  xbr_pkg::word_t        dividend,
  input  xbr_pkg::word_t        divisor,
  output xbr_pkg::word_t        remainder,
  output xbr_pkg::rem_status_t  status
);

  localparam logic [xbr_pkg::CntW-1:0] Steps = xbr_pkg::CntW'(xbr_pkg::WordW);
  localparam logic [xbr_pkg::CntW-1:0] One   = xbr_pkg::CntW'(1);

  logic [xbr_pkg::CntW-1:0]  cnt_r, cnt_nxt;
  logic                      done_r, done_nxt;
  xbr_pkg::word_t            dvd_r, dvd_nxt;
  xbr_pkg::word_t            dvs_r, dvs_nxt;
  xbr_pkg::word_t            rem_r, rem_nxt;
  logic [xbr_pkg::WordW:0]   trial;
  logic [xbr_pkg::WordW:0]   diff;

  assign trial = {rem_r, dvd_r[xbr_pkg::WordW-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt = Steps;
      dvd_nxt = dividend;
      dvs_nxt = divisor;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - One;
      dvd_nxt  = dvd_r << 1;
      done_nxt = (cnt_r == One);
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[xbr_pkg::WordW-1:0];
      end else begin
        rem_nxt = trial[xbr_pkg::WordW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign remainder   = rem_r;
  assign status.busy = (cnt_r != '0);
  assign status.done = done_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (cnt_r == '0))
    else $error("remainder unit started while busy");

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (cnt_r == '0) && $past(cnt_r == One))
    else $error("remainder done without final step");

  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && (dvs_r != '0)) |-> (rem_r < dvs_r))
    else $error("remainder not below divisor");

endmodule

`default_nettype wire

// File: test/xbr_checker.sv
// ----------------------------------------------------------------------------
// xbr_checker
// Watches the ports of the xorshift128+ random source and checks every result.
// It mirrors the seed registers from the cfg port and keeps its own copy of the
// generator state. For every accepted request it computes the value and the
// bad-bound flag that the block must return. Results are compared in order
// against these predictions, and the failure count goes back to the test top.
// ----------------------------------------------------------------------------
module xbr_checker
  import xbr_pkg::*;
(
  input  wire               clk,
  input  wire               rst_n,
  input  wire               cfg_we,
  input  wire               cfg_index,
  input  wire  [63:0]       cfg_wdata,
  input  wire               in_valid,
  input  wire               in_stall,
  input  wire  [1:0]        in_req_type,
  input  wire  [63:0]       in_bound,
  input  wire               out_valid,
  input  wire               out_stall,
  input  wire  [63:0]       out_value,
  input  wire               out_bad_bound,
  output int unsigned       n_fail,
  output int unsigned       n_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam word_t WordMax = '1;
  localparam int unsigned ReportMax = 10;

  typedef struct packed {
    word_t value;
    logic  bad_bound;
  } draw_result_t;

  word_t        seed_a;
  word_t        seed_b;
  word_t        gen_a;
  word_t        gen_b;
  draw_result_t result_q[$];

  initial begin
    n_fail    = 0;
    n_pending = 0;
  end

  function automatic word_t next_draw();
    word_t t;
    word_t u;
    t = gen_a;
    u = gen_b;
    gen_a = u;
    t = t ^ (t << ShiftA);
    gen_b = t ^ u ^ (t >> ShiftB) ^ (u >> ShiftC);
    return gen_b + u;
  endfunction

  task automatic serve_request(input logic [1:0] kind, input word_t n);
    draw_result_t r;
    word_t        lim;
    word_t        x;
    r = '0;
    case (kind)
      REQ_RAW: begin
        r.value = next_draw();
      end
      REQ_BOUNDED: begin
        if (n == '0) begin
          r.bad_bound = 1'b1;
        end else begin
          lim = n * (WordMax / n);
          do begin
            x = next_draw();
          end while (x >= lim);
          r.value = x % n;
        end
      end
      REQ_RESEED: begin
        gen_a = seed_a;
        gen_b = seed_b;
      end
      default: begin
      end
    endcase
    result_q.push_back(r);
  endtask

  task automatic note_mismatch(input string what, input word_t exp_v, input word_t got_v);
    n_fail++;
    if (n_fail <= ReportMax) begin
      $display("[%0t] %s mismatch: expected %h, got %h", $time, what, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    draw_result_t exp_r;
    if (!rst_n) begin
      seed_a = SEED_A_RST;
      seed_b = SEED_B_RST;
      gen_a  = SEED_A_RST;
      gen_b  = SEED_B_RST;
      result_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SEED_A) begin
          seed_a = cfg_wdata;
        end else begin
          seed_b = cfg_wdata;
        end
      end
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          note_mismatch("unexpected item", '0, out_value);
        end else begin
          exp_r = result_q.pop_front();
          if (out_value !== exp_r.value) begin
            note_mismatch("value", exp_r.value, out_value);
          end
          if (out_bad_bound !== exp_r.bad_bound) begin
            note_mismatch("bad_bound", word_t'(exp_r.bad_bound), word_t'(out_bad_bound));
          end
        end
      end
      if (in_valid && !in_stall) begin
        serve_request(in_req_type, in_bound);
      end
    end
    n_pending = result_q.size();
  end

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the xorshift128+ bounded random source.
// A directed part covers raw, bounded, reseed and unused requests, zero and
// extreme bounds, and all-zero and all-ones seeds. Three random phases follow
// with different idle patterns on both channels and a long receiver hold-off.
// Checking is done by xbr_checker, which runs beside the block.
// ----------------------------------------------------------------------------
module tb;
  import xbr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  REQ_UNUSED = 2'd3;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned PhaseItems = 425;
  localparam word_t       TopBit     = {1'b1, 63'd0};

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [63:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_req_type;
  logic [63:0] in_bound;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_value;
  logic        out_bad_bound;

  int unsigned n_fail;
  int unsigned n_pending;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 13;
  int unsigned recv_idle_pct = 64;
  int unsigned hold_len = 0;

  xorshift128_plus_bounded_random_top u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_bound      (in_bound),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value     (out_value),
    .out_bad_bound (out_bad_bound)
  );

  xbr_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_bound      (in_bound),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value     (out_value),
    .out_bad_bound (out_bad_bound),
    .n_fail        (n_fail),
    .n_pending     (n_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random, and holds off completely once when asked to.
  initial begin
    bit hold_used;
    hold_used = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if ((hold_len > 0) && !hold_used) begin
        hold_used = 1'b1;
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic word_t rand_bound();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return '0;
    if (sel <= 6) return word_t'($urandom_range(1, 20));
    if (sel <= 10) return rand_word() >> $urandom_range(0, 63);
    if (sel <= 12) return (word_t'(1) << $urandom_range(0, 63)) + word_t'($urandom_range(0, 3));
    if (sel <= 16) return rand_word() | TopBit;
    if (sel == 17) return '1;
    return rand_word();
  endfunction

  task automatic send_item(input logic [1:0] kind, input word_t n);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= kind;
    in_bound    <= n;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_seeds(input word_t a, input word_t b);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SEED_A;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_index <= CFG_SEED_B;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_random(input int unsigned n_items);
    int unsigned pick;
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) send_item(REQ_RAW, rand_word());
      else if (pick < 85) send_item(REQ_BOUNDED, rand_bound());
      else if (pick < 93) send_item(REQ_RESEED, rand_word());
      else send_item(REQ_UNUSED, rand_word());
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= CFG_SEED_A;
    cfg_wdata   <= '0;
    in_valid    <= 1'b0;
    in_req_type <= REQ_RAW;
    in_bound    <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset seeds: every request kind, extreme bounds and zero bound.
    send_item(REQ_RAW, '0);
    send_item(REQ_RAW, '1);
    send_item(REQ_BOUNDED, 64'd1);
    send_item(REQ_BOUNDED, 64'd2);
    send_item(REQ_BOUNDED, 64'd3);
    send_item(REQ_BOUNDED, '1);
    send_item(REQ_BOUNDED, 64'h8000_0000_0000_0000);
    send_item(REQ_BOUNDED, 64'h8000_0000_0000_0001);
    send_item(REQ_BOUNDED, 64'hC000_0000_0000_0000);
    send_item(REQ_BOUNDED, '0);
    send_item(REQ_UNUSED, 64'd5);
    send_item(REQ_UNUSED, '1);
    send_item(REQ_RESEED, '1);
    send_item(REQ_RAW, 64'd0);
    drain();

    // An all-zero state stays at zero.
    write_seeds('0, '0);
    send_item(REQ_RESEED, '0);
    send_item(REQ_RAW, '0);
    send_item(REQ_BOUNDED, 64'd7);
    send_item(REQ_BOUNDED, '1);
    send_item(REQ_BOUNDED, '0);
    drain();

    write_seeds('1, '1);
    send_item(REQ_RESEED, '0);
    send_item(REQ_RAW, '0);
    send_item(REQ_BOUNDED, 64'd100);
    send_item(REQ_RAW, '1);
    drain();

    write_seeds(rand_word(), rand_word());
    send_idle_pct = 13;
    recv_idle_pct = 64;
    run_random(PhaseItems);
    drain();

    write_seeds(rand_word(), '1);
    send_idle_pct = 64;
    recv_idle_pct = 13;
    run_random(PhaseItems);
    drain();

    // No idling here, and the receiver holds off long enough to back up the input.
    write_seeds(rand_word(), rand_word());
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_len = 300;
    run_random(PhaseItems);
    drain();
    repeat (70) @(posedge clk);

    if (n_fail == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/xbr_pkg.sv
rtl/core/xbr_step.sv
rtl/core/xbr_rem.sv
rtl/core/xorshift128_plus_bounded_random_top.sv
test/xbr_checker.sv
test/tb.sv
